// File: rtl/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types and constants of the peak limiter: field widths, register
// indexes, reset values and the sequencer state encoding.
// ----------------------------------------------------------------------------
package plm_pkg;

  localparam int SAMPLE_BITS = 24;

  localparam int GAIN_W    = 24;  // Q1.23 gain
  localparam int FRAC_W    = 23;  // fraction bits of gain
  localparam int THR_W     = 23;  // Q0.23 threshold
  localparam int COEF_W    = 24;  // Q0.24 smoothing weights
  localparam int CFG_W     = 24;  // widest register
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_ONE    = 24'h800000;
  localparam logic [THR_W-1:0]  THR_RESET   = 23'd7476355;
  localparam logic [COEF_W-1:0] ATT_RESET   = 24'd16431308;
  localparam logic [COEF_W-1:0] REL_RESET   = 24'd16772847;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_GLOAD,
    ST_GAIN,
    ST_SLOAD,
    ST_SCALE,
    ST_FIN
  } plm_state_e;

  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic mul_start;
    logic gain_load;
    logic res_load;
    logic out_load;
  } plm_ctrl_t;

endpackage

// File: rtl/plm_in_if.sv
// ----------------------------------------------------------------------------
// plm_in_if
// Input sample channel: valid/ready handshake with one signed sample.
// ----------------------------------------------------------------------------
interface plm_in_if #(
  parameter int SAMPLE_BITS = plm_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// File: rtl/plm_out_if.sv
// ----------------------------------------------------------------------------
// plm_out_if
// Output channel: valid/ready handshake with limited sample and current gain.
// ----------------------------------------------------------------------------
interface plm_out_if #(
  parameter int SAMPLE_BITS = plm_pkg::SAMPLE_BITS
);
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_BITS-1:0]   sample_out;
  logic [plm_pkg::GAIN_W-1:0]      gain_now;

  modport source (output valid, output sample_out, output gain_now, input ready);
  modport sink   (input valid, input sample_out, input gain_now, output ready);
endinterface

// File: rtl/peak_limiter_attack_release.sv
// ----------------------------------------------------------------------------
// peak_limiter_attack_release
// Feedforward peak limiter with attack/release gain smoothing, bit-serial.
// Above threshold a word takes the 23-step serial divide and two 24-step
// serial multiplies, below it only the multiplies, with limiting off neither.
// One word in flight; the next can be accepted as its output word turns valid.
// Reset: registers to defaults, gain to unity, no word pending.
// ----------------------------------------------------------------------------
module peak_limiter_attack_release #(
  parameter int SAMPLE_BITS = plm_pkg::SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  plm_in_if.sink                        in_i,
  plm_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [plm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [plm_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int SW     = SAMPLE_BITS;
  localparam int GW     = plm_pkg::GAIN_W;
  localparam int FW     = plm_pkg::FRAC_W;
  localparam int NW     = plm_pkg::THR_W + SW - 1;   // threshold numerator
  localparam int CW     = SW + FW;                   // compare width
  localparam int AW     = (SW + 1 > GW + 1) ? SW + 1 : GW + 1;

  // configuration
  logic [plm_pkg::THR_W-1:0]  thr_q;
  logic [plm_pkg::COEF_W-1:0] att_q, rel_q;
  logic                       en_q;

  plm_pkg::plm_state_e state_q, state_d;
  plm_pkg::plm_ctrl_t  ctrl;

  logic [SW-1:0] raw_q, mag_q, res_q;
  logic          neg_q;
  logic [GW-1:0] target_q, gain_q, g_new;

  logic          out_valid_q;
  logic [SW-1:0] out_sample_q;
  logic [GW-1:0] out_gain_q;

  logic                  in_acc;
  logic [NW-1:0]         num;
  logic                  over;
  logic [plm_pkg::COEF_W-1:0] coef;
  logic signed [GW:0]    diff_g;
  logic signed [AW-1:0]  mul_a;
  logic [GW-1:0]         mul_b;
  logic                  mul_done, div_done;
  logic signed [AW-1:0]  prod_hi;
  logic [GW-1:0]         prod_lo;
  logic [FW-1:0]         quot;
  logic [AW:0]           g_sum;
  logic [SW:0]           floor_s, ceil_s, neg_s;
  logic [SW-1:0]         res_new;
  logic [SW-1:0]         in_mag;

  assign in_acc = in_i.valid & ctrl.in_ready;

  always_comb begin
    in_mag = in_i.sample_in[SW-1] ? (SW'(0) - in_i.sample_in) : in_i.sample_in;
    num    = {thr_q, {(SW-1){1'b0}}};
    over   = {mag_q, {FW{1'b0}}} > CW'(num);
    coef   = (target_q < gain_q) ? att_q : rel_q;
    diff_g = $signed({1'b0, gain_q}) - $signed({1'b0, target_q});
    mul_a  = (state_q == plm_pkg::ST_GLOAD) ? AW'(diff_g) : $signed(AW'({1'b0, mag_q}));
    mul_b  = (state_q == plm_pkg::ST_GLOAD) ? coef : gain_q;
  end

  // new gain: target + round(coef * (gain - target) / 2^24), capped at unity
  always_comb begin
    g_sum = (AW+1)'({1'b0, target_q}) + (AW+1)'(prod_hi) + (AW+1)'(prod_lo[GW-1]);
    g_new = (g_sum > (AW+1)'(plm_pkg::GAIN_ONE)) ? plm_pkg::GAIN_ONE : g_sum[GW-1:0];
  end

  // output sample: floor for positive, minus ceiling of magnitude for negative
  always_comb begin
    floor_s = (SW+1)'({prod_hi, prod_lo[FW]});
    ceil_s  = floor_s + (SW+1)'(|prod_lo[FW-1:0]);
    neg_s   = (SW+1)'(0) - ceil_s;
    res_new = neg_q ? neg_s[SW-1:0] : floor_s[SW-1:0];
  end

  plm_div #(
    .D_W (SW),
    .Q_W (FW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.div_start),
    .hi_i    (num[NW-1:FW]),
    .lo_i    (num[FW-1:0]),
    .den_i   (mag_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  plm_mul #(
    .A_W (AW),
    .B_W (GW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .hi_o    (prod_hi),
    .lo_o    (prod_lo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plm_pkg::ST_IDLE:  if (in_i.valid) state_d = plm_pkg::ST_TEST;
      plm_pkg::ST_TEST: begin
        if (!en_q)     state_d = plm_pkg::ST_FIN;
        else if (over) state_d = plm_pkg::ST_DIV;
        else           state_d = plm_pkg::ST_GLOAD;
      end
      plm_pkg::ST_DIV:   if (div_done) state_d = plm_pkg::ST_GLOAD;
      plm_pkg::ST_GLOAD: state_d = plm_pkg::ST_GAIN;
      plm_pkg::ST_GAIN:  if (mul_done) state_d = plm_pkg::ST_SLOAD;
      plm_pkg::ST_SLOAD: state_d = plm_pkg::ST_SCALE;
      plm_pkg::ST_SCALE: if (mul_done) state_d = plm_pkg::ST_FIN;
      plm_pkg::ST_FIN:   if (!out_valid_q || out_o.ready) state_d = plm_pkg::ST_IDLE;
      default:           state_d = plm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      plm_pkg::ST_IDLE:  ctrl.in_ready  = 1'b1;
      plm_pkg::ST_TEST:  ctrl.div_start = en_q & over;
      plm_pkg::ST_DIV:   ctrl = '0;
      plm_pkg::ST_GLOAD: ctrl.mul_start = 1'b1;
      plm_pkg::ST_GAIN:  ctrl.gain_load = mul_done;
      plm_pkg::ST_SLOAD: ctrl.mul_start = 1'b1;
      plm_pkg::ST_SCALE: ctrl.res_load  = mul_done;
      plm_pkg::ST_FIN:   ctrl.out_load  = ~out_valid_q | out_o.ready;
      default:           ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plm_pkg::ST_IDLE;
      thr_q       <= plm_pkg::THR_RESET;
      att_q       <= plm_pkg::ATT_RESET;
      rel_q       <= plm_pkg::REL_RESET;
      en_q        <= 1'b1;
      gain_q      <= plm_pkg::GAIN_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          plm_pkg::REG_THRESHOLD: thr_q <= cfg_data_i[plm_pkg::THR_W-1:0];
          plm_pkg::REG_ATTACK:    att_q <= cfg_data_i[plm_pkg::COEF_W-1:0];
          plm_pkg::REG_RELEASE:   rel_q <= cfg_data_i[plm_pkg::COEF_W-1:0];
          plm_pkg::REG_ENABLE:    en_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (ctrl.gain_load) gain_q <= g_new;
      if (ctrl.out_load)  out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_q <= in_i.sample_in;
      neg_q <= in_i.sample_in[SW-1];
      mag_q <= in_mag;
    end
    if (state_q == plm_pkg::ST_TEST) begin
      res_q    <= raw_q;
      target_q <= plm_pkg::GAIN_ONE;
    end
    if (state_q == plm_pkg::ST_DIV && div_done) target_q <= {1'b0, quot};
    if (ctrl.res_load) res_q <= res_new;
    if (ctrl.out_load) begin
      out_sample_q <= res_q;
      out_gain_q   <= gain_q;
    end
  end

  assign in_i.ready       = ctrl.in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.gain_now   = out_gain_q;

endmodule

// File: rtl/plm_div.sv
// ----------------------------------------------------------------------------
// plm_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// upper numerator part is below the divisor, so the quotient fits Q_W bits.
// ----------------------------------------------------------------------------
module plm_div #(
  parameter int D_W = plm_pkg::SAMPLE_BITS,
  parameter int Q_W = plm_pkg::FRAC_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [D_W-2:0] hi_i,
  input  logic [Q_W-1:0] lo_i,
  input  logic [D_W-1:0] den_i,
  output logic           done_o,
  output logic [Q_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(Q_W);

  logic [D_W-2:0]   rem_q, rem_d;
  logic [Q_W-1:0]   lo_q;
  logic [Q_W-1:0]   quot_q;
  logic [D_W-1:0]   den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [D_W-1:0] trial;
  logic [D_W:0]   diff;
  logic           ge;

  always_comb begin
    trial = {rem_q, lo_q[Q_W-1]};
    diff  = {1'b0, trial} - {1'b0, den_q};
    ge    = ~diff[D_W];
    rem_d = ge ? diff[D_W-2:0] : trial[D_W-2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(Q_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= hi_i;
      lo_q   <= lo_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      lo_q   <= {lo_q[Q_W-2:0], 1'b0};
      quot_q <= {quot_q[Q_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/plm_mul.sv
// ----------------------------------------------------------------------------
// plm_mul
// Serial shift-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle. Product is {hi_o, lo_o}.
// ----------------------------------------------------------------------------
module plm_mul #(
  parameter int A_W = plm_pkg::GAIN_W + 1,
  parameter int B_W = plm_pkg::COEF_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [A_W-1:0] a_i,
  input  logic [B_W-1:0]        b_i,
  output logic                  done_o,
  output logic signed [A_W-1:0] hi_o,
  output logic [B_W-1:0]        lo_o
);

  localparam int CNT_W = $clog2(B_W);

  logic [A_W-1:0]   a_q;
  logic [A_W-1:0]   acc_q;
  logic [B_W-1:0]   b_q;
  logic [B_W-1:0]   lo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [A_W:0]     sum;

  // acc is kept halved each step; the dropped bit feeds the low product word
  always_comb begin
    sum = {acc_q[A_W-1], acc_q} + (b_q[0] ? {a_q[A_W-1], a_q} : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
      lo_q  <= '0;
    end else if (busy_q) begin
      acc_q <= sum[A_W:1];
      lo_q  <= {sum[0], lo_q[B_W-1:1]};
      b_q   <= {1'b0, b_q[B_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign hi_o   = $signed(acc_q);
  assign lo_o   = lo_q;

endmodule

// File: rtl/plm_checker.sv
// ----------------------------------------------------------------------------
// plm_checker
// Port-level checks of the peak limiter, bound to the top level.
// ----------------------------------------------------------------------------
module plm_checker #(
  parameter int SAMPLE_BITS = plm_pkg::SAMPLE_BITS
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [SAMPLE_BITS-1:0]     out_sample_i,
  input logic [plm_pkg::GAIN_W-1:0] out_gain_i
);

  // one word in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted while a word is in flight");

  // a result never appears in the cycle right after an accept
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("output word appeared too early");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_gain_i <= plm_pkg::GAIN_ONE))
    else $error("gain above unity");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_sample_i) && $stable(out_gain_i)))
    else $error("stalled output word changed");

endmodule

bind peak_limiter_attack_release plm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_plm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample_out),
  .out_gain_i   (out_o.gain_now)
);

// File: tb/tb_peak_limiter_attack_release.sv
// ----------------------------------------------------------------------------
// tb_peak_limiter_attack_release
// Self-checking bench for the peak limiter. A bit-exact model of the gain
// smoother predicts every output word from the accepted samples and the
// register settings. Directed cases cover reset defaults, full-scale and
// threshold-edge samples, zero threshold, stalled release and bypass. Random
// phases then sweep register settings with bursts of loud, quiet and noise
// samples, with random idling on both sides in all phases but one.
// ----------------------------------------------------------------------------
module tb_peak_limiter_attack_release;
  import plm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int FULL_SCALE   = 2**(SAMPLE_BITS-1) - 1;
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_ITEMS  = 236;
  localparam int IDLE_PERCENT = 12;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [GAIN_W-1:0]             gain;
  } limit_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  plm_in_if  in_if ();
  plm_out_if out_if ();

  peak_limiter_attack_release DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // model copy of registers and gain
  logic [THR_W-1:0]  thr_level;
  logic [COEF_W-1:0] att_weight;
  logic [COEF_W-1:0] rel_weight;
  logic              lim_on;
  logic [GAIN_W-1:0] gain_state;

  limit_word_t limited_q[$];
  limit_word_t next_word;

  int  errors        = 0;
  int  samples_sent  = 0;
  int  words_checked = 0;
  int  words_reduced = 0;
  int  settings_used = 0;
  int  cycle_count   = 0;
  bit  steady        = 1'b0;  // no idling on either side

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_peak_limiter_attack_release: FAIL");
      $finish;
    end
  end

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  // bit-exact gain smoother and output scaler
  function automatic limit_word_t predict_limiter(input logic signed [SAMPLE_BITS-1:0] s);
    logic [63:0] raw, mag, lhs, num, target, coef, g, prod, res;
    logic        neg;
    limit_word_t w;
    raw = '0;
    raw[SAMPLE_BITS-1:0] = s;
    neg = s[SAMPLE_BITS-1];
    mag = neg ? ((64'd1 << SAMPLE_BITS) - raw) : raw;
    if (!lim_on) begin
      w.sample = s;
      w.gain   = gain_state;
      return w;
    end
    lhs    = mag << FRAC_W;
    num    = 64'(thr_level) << (SAMPLE_BITS - 1);
    target = (lhs > num) ? num / mag : 64'(GAIN_ONE);
    coef   = (target < 64'(gain_state)) ? 64'(att_weight) : 64'(rel_weight);
    g = (coef * 64'(gain_state) + ((64'd1 << COEF_W) - coef) * target
         + (64'd1 << (COEF_W - 1))) >> COEF_W;
    if (g > 64'(GAIN_ONE)) g = 64'(GAIN_ONE);
    gain_state = g[GAIN_W-1:0];
    prod = mag * g;
    if (neg) begin
      // floor of a negative product
      res = (prod + 64'(GAIN_ONE) - 64'd1) >> FRAC_W;
      res = 64'd0 - res;
    end else begin
      res = prod >> FRAC_W;
    end
    w.sample = res[SAMPLE_BITS-1:0];
    w.gain   = g[GAIN_W-1:0];
    return w;
  endfunction

  // output side: random stalls unless steady
  always @(posedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_checked++;
      if (out_if.gain_now < GAIN_ONE) words_reduced++;
      if (limited_q.size() == 0) begin
        note_error($sformatf("word with none expected: sample %0d gain %0d",
                             out_if.sample_out, out_if.gain_now));
      end else begin
        next_word = limited_q.pop_front();
        if (out_if.sample_out !== next_word.sample)
          note_error($sformatf("sample_out expected %0d got %0d",
                               next_word.sample, out_if.sample_out));
        if (out_if.gain_now !== next_word.gain)
          note_error($sformatf("gain_now expected %0d got %0d",
                               next_word.gain, out_if.gain_now));
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= s;
    do @(posedge clk_i); while (!in_if.ready);
    limited_q.push_back(predict_limiter(s));
    samples_sent++;
  endtask

  // stop sending and wait for every outstanding word
  task automatic settle();
    in_if.valid <= 1'b0;
    while (limited_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_level  = value[THR_W-1:0];
      REG_ATTACK:    att_weight = value[COEF_W-1:0];
      REG_RELEASE:   rel_weight = value[COEF_W-1:0];
      REG_ENABLE:    lim_on     = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // unused upper bits of the threshold and enable writes carry junk; only the register width must stick
  task automatic set_config(input logic [31:0] thr, input logic [31:0] att,
                            input logic [31:0] rel, input logic en);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_THRESHOLD, {junk[CFG_W-1], thr[THR_W-1:0]});
    write_reg(REG_ATTACK, att[COEF_W-1:0]);
    write_reg(REG_RELEASE, rel[COEF_W-1:0]);
    write_reg(REG_ENABLE, {junk[CFG_W-1:1], en});
    settings_used++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int kind);
    logic [31:0] r, m, neg_m;
    r = $urandom;
    if (kind < 3) return r[SAMPLE_BITS-1:0];
    if (kind < 7) begin
      m = $urandom_range(FULL_SCALE, thr_level);
    end else if (kind < 9) begin
      m = $urandom_range(thr_level, 0) >> $urandom_range(0, 8);
    end else begin
      case (r[1:0])
        2'd0: m = 0;
        2'd1: m = FULL_SCALE;
        2'd2: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        default: m = thr_level;
      endcase
    end
    neg_m = 32'd0 - m;
    return r[31] ? neg_m[SAMPLE_BITS-1:0] : m[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [31:0] fast_weight();
    return ($urandom_range(0, 3) == 0) ? $urandom : (32'd1 << COEF_W) - $urandom_range(1, 1 << 20);
  endfunction

  function automatic logic [31:0] slow_weight();
    return ($urandom_range(0, 3) == 0) ? $urandom : (32'd1 << COEF_W) - $urandom_range(1, 1 << 14);
  endfunction

  // reset values, full scale both ways, samples on either side of threshold
  task automatic test_default_levels();
    send_sample(0);
    send_sample(1);
    send_sample(-1);
    send_sample(FULL_SCALE);
    send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    send_sample(THR_RESET);
    send_sample(-(THR_RESET + 1));
    send_sample(THR_RESET + 1);
    send_sample(1000);
    settle();
  endtask

  // threshold of zero: nonzero samples drive the gain to zero
  task automatic test_zero_threshold();
    set_config(0, 0, 0, 1'b1);
    send_sample(5);
    send_sample(-5);
    send_sample(0);
    send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    settle();
  endtask

  // slowest release: rounded step toward unity is zero, gain stays low
  task automatic test_stalled_release();
    set_config(1 << (THR_W - 1), 0, (1 << COEF_W) - 1, 1'b1);
    send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    send_sample(100);
    send_sample(-100);
    send_sample(0);
    settle();
  endtask

  // limiting off passes samples and holds gain, then highest threshold
  task automatic test_bypass();
    set_config(THR_RESET, ATT_RESET, REL_RESET, 1'b0);
    send_sample(FULL_SCALE);
    send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    send_sample(12345);
    settle();
    set_config((1 << THR_W) - 1, ATT_RESET, REL_RESET, 1'b1);
    send_sample(FULL_SCALE);
    send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    settle();
  endtask

  // register settings swept phase by phase, bursts of one kind of sample
  task automatic test_random_program();
    int  count;
    int  kind;
    int  burst;
    bit  paused;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: set_config(THR_RESET, ATT_RESET, REL_RESET, 1'b1);
        1: set_config(1, fast_weight(), slow_weight(), 1'b1);
        2: set_config((1 << THR_W) - 1, 0, 0, 1'b1);
        3: set_config($urandom, (1 << COEF_W) - 1, (1 << COEF_W) - 1, 1'b1);
        4: set_config($urandom, fast_weight(), slow_weight(), 1'b0);
        5: set_config($urandom_range(1 << 20, (1 << THR_W) - 1), fast_weight(),
                      slow_weight(), 1'b1);
        default: set_config($urandom, $urandom, $urandom, 1'b1);
      endcase
      steady = (ph == 5);
      count  = 0;
      paused = 1'b0;
      while (count < PHASE_ITEMS) begin
        kind  = $urandom_range(0, 9);
        burst = $urandom_range(4, 40);
        for (int i = 0; i < burst && count < PHASE_ITEMS; i++) begin
          send_sample(pick_sample(kind));
          count++;
        end
        if (ph == 3 && !paused && count >= PHASE_ITEMS / 2) begin
          settle();
          paused = 1'b1;
        end
      end
      settle();
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.sample_in <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    thr_level  = THR_RESET;
    att_weight = ATT_RESET;
    rel_weight = REL_RESET;
    lim_on     = 1'b1;
    gain_state = GAIN_ONE;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_levels();
    test_zero_threshold();
    test_stalled_release();
    test_bypass();
    test_random_program();

    repeat (100) @(posedge clk_i);
    $display("Covered %0d samples over %0d register settings; %0d words checked,",
             samples_sent, settings_used, words_checked);
    $display("%0d with gain below unity, %0d mismatches.", words_reduced, errors);
    if (errors == 0 && limited_q.size() == 0) begin
      $display("tb_peak_limiter_attack_release: PASS");
    end else begin
      $display("tb_peak_limiter_attack_release: FAIL");
    end
    $finish;
  end

endmodule
